>>> rtl/ubfs_pkg.sv
// shared types and constants for the uart baud and frame set-up block
`default_nettype none
package ubfs_pkg;

  localparam int unsigned SLOW_HZ     = 32768;
  localparam int unsigned FAST_HZ     = 1000000;
  localparam int unsigned SLOW_MAX    = 9600;
  localparam int unsigned MIN_BAUD    = 300;
  localparam int unsigned MAX_BAUD    = 115200;
  localparam int unsigned PERCENT     = 100;

  localparam int BAUD_W  = 17;
  localparam int PCT_W   = 24;   // 100 * baud
  localparam int REM_W   = 20;   // dividend of the divisor chain
  localparam int QUO_W   = 7;    // divisor never exceeds 109
  localparam int CNT_W   = 10;   // clocks counted over up to eight bits
  localparam int SUM_W   = 4;
  localparam int PROD_W  = 34;   // 100 * baud * count
  localparam int STEPS   = 8;

  // floor(y / 15625) == (y * RECIP) >> RECIP_SH for y < 2**28
  localparam int          RED_W    = 28;
  localparam int          RECIP_W  = 29;
  localparam int          RECIP_SH = 42;
  localparam logic [RECIP_W-1:0] RECIP = 29'd281474977;
  localparam int          WIDE_W   = RED_W + RECIP_W;
  localparam int          QT_W     = PROD_W - 15;   // quotient width

  // parity letters
  localparam logic [7:0] CH_N_LO = 8'h6e;
  localparam logic [7:0] CH_N_UP = 8'h4e;
  localparam logic [7:0] CH_P_LO = 8'h70;
  localparam logic [7:0] CH_P_UP = 8'h50;
  localparam logic [7:0] CH_O_LO = 8'h6f;
  localparam logic [7:0] CH_O_UP = 8'h4f;

  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [PCT_W-1:0]  pct;
    logic              fast;
    logic              ok;
    logic              pen;
    logic              pev;
    logic              eight;
    logic              two;
    logic              port;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/ubfs_div_cell.sv
// one restoring step of the clock / baud divider chain
`default_nettype none
module ubfs_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_valid,
  input  ubfs_pkg::item_t                in_item,
  input  wire [ubfs_pkg::REM_W-1:0]      in_rem,
  input  wire [ubfs_pkg::QUO_W-1:0]      in_quo,
  output logic                           out_valid,
  output ubfs_pkg::item_t                out_item,
  output logic [ubfs_pkg::REM_W-1:0]     out_rem,
  output logic [ubfs_pkg::QUO_W-1:0]     out_quo
);

  localparam int CMP_W = ubfs_pkg::BAUD_W + ubfs_pkg::QUO_W;

  logic [CMP_W-1:0] shifted;
  logic             fits;

  assign shifted = CMP_W'(in_item.baud) << SHIFT;
  assign fits    = CMP_W'(in_rem) >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_rem  <= fits ? ubfs_pkg::REM_W'(CMP_W'(in_rem) - shifted) : in_rem;
      out_quo  <= in_quo | (ubfs_pkg::QUO_W'(fits) << SHIFT);
    end
  end

endmodule
`default_nettype wire

>>> rtl/ubfs_mod_cell.sv
// one modulation bit: error with and without an extra clock, three stages
`default_nettype none
module ubfs_mod_cell #(
  parameter int STEP = 0
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_valid,
  input  ubfs_pkg::item_t                in_item,
  input  wire [ubfs_pkg::QUO_W-1:0]      in_div,
  input  wire [ubfs_pkg::CNT_W-1:0]      in_acc,
  input  wire [ubfs_pkg::SUM_W-1:0]      in_sum,
  input  wire [ubfs_pkg::STEPS-1:0]      in_mask,
  output logic                           out_valid,
  output ubfs_pkg::item_t                out_item,
  output logic [ubfs_pkg::QUO_W-1:0]     out_div,
  output logic [ubfs_pkg::CNT_W-1:0]     out_acc,
  output logic [ubfs_pkg::SUM_W-1:0]     out_sum,
  output logic [ubfs_pkg::STEPS-1:0]     out_mask
);

  localparam int E_W = ubfs_pkg::QT_W + 1;
  localparam logic [E_W-1:0] IDEAL = E_W'(ubfs_pkg::PERCENT * (STEP + 1));

  // stage a: clock count and both products
  logic                          a_valid;
  ubfs_pkg::item_t               a_item;
  logic [ubfs_pkg::QUO_W-1:0]    a_div;
  logic [ubfs_pkg::CNT_W-1:0]    a_cnt;
  logic [ubfs_pkg::SUM_W-1:0]    a_sum;
  logic [ubfs_pkg::STEPS-1:0]    a_mask;
  logic [ubfs_pkg::PROD_W-1:0]   a_p0, a_p1;
  // stage b: reciprocal products for the fast clock, shifts for the slow one
  logic                          b_valid;
  ubfs_pkg::item_t               b_item;
  logic [ubfs_pkg::QUO_W-1:0]    b_div;
  logic [ubfs_pkg::CNT_W-1:0]    b_cnt;
  logic [ubfs_pkg::SUM_W-1:0]    b_sum;
  logic [ubfs_pkg::STEPS-1:0]    b_mask;
  logic [ubfs_pkg::WIDE_W-1:0]   b_m0, b_m1;
  logic [ubfs_pkg::QT_W-1:0]     b_s0, b_s1;

  logic [ubfs_pkg::CNT_W-1:0]    cnt;
  logic [ubfs_pkg::PROD_W-1:0]   p0;
  logic [ubfs_pkg::QT_W-1:0]     q0, q1;
  logic [E_W-1:0]                e0, e1, a0, a1;
  logic                          better;

  assign cnt = in_acc + ubfs_pkg::CNT_W'(in_div);
  assign p0  = ubfs_pkg::PROD_W'(in_item.pct) * ubfs_pkg::PROD_W'(cnt);

  assign q0 = b_item.fast ? ubfs_pkg::QT_W'(b_m0 >> ubfs_pkg::RECIP_SH) : b_s0;
  assign q1 = b_item.fast ? ubfs_pkg::QT_W'(b_m1 >> ubfs_pkg::RECIP_SH) : b_s1;
  assign e0 = E_W'(q0) - IDEAL;
  assign e1 = E_W'(q1) - IDEAL;
  assign a0 = e0[E_W-1] ? E_W'(-e0) : e0;
  assign a1 = e1[E_W-1] ? E_W'(-e1) : e1;
  assign better = a1 < a0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      a_div  <= in_div;
      a_cnt  <= cnt;
      a_sum  <= in_sum;
      a_mask <= in_mask;
      a_p0   <= p0;
      a_p1   <= p0 + ubfs_pkg::PROD_W'(in_item.pct);

      b_item <= a_item;
      b_div  <= a_div;
      b_cnt  <= a_cnt;
      b_sum  <= a_sum;
      b_mask <= a_mask;
      b_m0   <= ubfs_pkg::WIDE_W'(a_p0[ubfs_pkg::PROD_W-1:6]) *
                ubfs_pkg::WIDE_W'(ubfs_pkg::RECIP);
      b_m1   <= ubfs_pkg::WIDE_W'(a_p1[ubfs_pkg::PROD_W-1:6]) *
                ubfs_pkg::WIDE_W'(ubfs_pkg::RECIP);
      b_s0   <= a_p0[ubfs_pkg::PROD_W-1:15];
      b_s1   <= a_p1[ubfs_pkg::PROD_W-1:15];

      out_item <= b_item;
      out_div  <= b_div;
      out_acc  <= b_cnt + ubfs_pkg::CNT_W'(better);
      out_sum  <= b_sum + ubfs_pkg::SUM_W'(better);
      out_mask <= b_mask | (ubfs_pkg::STEPS'(better) << STEP);
    end
  end

endmodule
`default_nettype wire

>>> rtl/uart_baud_and_frame_setup.sv
// top level: request decode, divider chain, modulation chain, output register
//
//  channel | signals                   | direction | payload
//  --------+---------------------------+-----------+---------------------------
//  s       | s_tvalid s_tready s_tdata | in        | one set-up request
//  m       | m_tvalid m_tready m_tdata | out       | one result per request
//
// one transaction in and out per cycle while m is not stalled; the stages are
// decode 1, divider chain 7, modulation chain 8 cells x 3, output 1
// the pipeline advances as a whole whenever the output register is free or
// being taken, so a stall on m holds every stage and drops s_tready
// reset clears the valid bits only
`default_nettype none
module uart_baud_and_frame_setup (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // baud_rate[16:0] parity_char[24:17] data_bits[32:25] stop_bits[40:33]
  // port[41], zero fill above
  input  wire  [47:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // ok[0] clock_source[1] divisor[17:2] modulation[25:18] parity_enable[26]
  // parity_even[27] eight_bit_chars[28] two_stop_bits[29] target_port[30]
  // zero fill above
  output logic [31:0] m_tdata
);

  localparam int NDIV = ubfs_pkg::QUO_W;
  localparam int NMOD = ubfs_pkg::STEPS;

  logic en;

  // request fields
  logic [ubfs_pkg::BAUD_W-1:0] baud;
  logic [7:0] pch, dbits, sbits;
  logic       port;
  logic       baud_ok, par_ok, pen, pev;
  ubfs_pkg::item_t dec;

  assign baud  = s_tdata[16:0];
  assign pch   = s_tdata[24:17];
  assign dbits = s_tdata[32:25];
  assign sbits = s_tdata[40:33];
  assign port  = s_tdata[41];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign baud_ok = (baud >= ubfs_pkg::BAUD_W'(ubfs_pkg::MIN_BAUD)) &&
                   (baud <= ubfs_pkg::BAUD_W'(ubfs_pkg::MAX_BAUD));

  always_comb begin
    par_ok = 1'b1;
    pen    = 1'b0;
    pev    = 1'b0;
    priority if (pch == ubfs_pkg::CH_N_LO || pch == ubfs_pkg::CH_N_UP) begin
      pen = 1'b0;
    end else if (pch == ubfs_pkg::CH_P_LO || pch == ubfs_pkg::CH_P_UP) begin
      pen = 1'b1;
      pev = 1'b1;
    end else if (pch == ubfs_pkg::CH_O_LO || pch == ubfs_pkg::CH_O_UP) begin
      pen = 1'b1;
    end else begin
      par_ok = 1'b0;
    end
  end

  always_comb begin
    dec.baud  = baud;
    dec.pct   = ubfs_pkg::PCT_W'(baud) * ubfs_pkg::PCT_W'(ubfs_pkg::PERCENT);
    dec.fast  = baud > ubfs_pkg::BAUD_W'(ubfs_pkg::SLOW_MAX);
    dec.ok    = baud_ok && par_ok && (dbits == 8'd7 || dbits == 8'd8) &&
                (sbits == 8'd1 || sbits == 8'd2);
    dec.pen   = pen;
    dec.pev   = pev;
    dec.eight = dbits == 8'd8;
    dec.two   = sbits == 8'd2;
    dec.port  = port;
  end

  // decode register feeds the divider chain
  logic                        d_valid;
  ubfs_pkg::item_t             d_item;
  logic [ubfs_pkg::REM_W-1:0]  d_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_item <= dec;
      d_rem  <= dec.fast ? ubfs_pkg::REM_W'(ubfs_pkg::FAST_HZ)
                         : ubfs_pkg::REM_W'(ubfs_pkg::SLOW_HZ);
    end
  end

  // divider chain, most significant quotient bit first
  logic                        dv   [NDIV+1];
  ubfs_pkg::item_t             ditm [NDIV+1];
  logic [ubfs_pkg::REM_W-1:0]  drem [NDIV+1];
  logic [ubfs_pkg::QUO_W-1:0]  dquo [NDIV+1];

  assign dv[0]   = d_valid;
  assign ditm[0] = d_item;
  assign drem[0] = d_rem;
  assign dquo[0] = '0;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    ubfs_div_cell #(.SHIFT(NDIV - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv[k]),
      .in_item   (ditm[k]),
      .in_rem    (drem[k]),
      .in_quo    (dquo[k]),
      .out_valid (dv[k+1]),
      .out_item  (ditm[k+1]),
      .out_rem   (drem[k+1]),
      .out_quo   (dquo[k+1])
    );
  end

  // modulation chain, one cell per mask bit, running sum handed along
  logic                         mv    [NMOD+1];
  ubfs_pkg::item_t              mitm  [NMOD+1];
  logic [ubfs_pkg::QUO_W-1:0]   mdiv  [NMOD+1];
  logic [ubfs_pkg::CNT_W-1:0]   macc  [NMOD+1];
  logic [ubfs_pkg::SUM_W-1:0]   msum  [NMOD+1];
  logic [ubfs_pkg::STEPS-1:0]   mmask [NMOD+1];

  assign mv[0]    = dv[NDIV];
  assign mitm[0]  = ditm[NDIV];
  assign mdiv[0]  = dquo[NDIV];
  assign macc[0]  = '0;
  assign msum[0]  = '0;
  assign mmask[0] = '0;

  for (genvar k = 0; k < NMOD; k++) begin : g_mod
    ubfs_mod_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (mv[k]),
      .in_item   (mitm[k]),
      .in_div    (mdiv[k]),
      .in_acc    (macc[k]),
      .in_sum    (msum[k]),
      .in_mask   (mmask[k]),
      .out_valid (mv[k+1]),
      .out_item  (mitm[k+1]),
      .out_div   (mdiv[k+1]),
      .out_acc   (macc[k+1]),
      .out_sum   (msum[k+1]),
      .out_mask  (mmask[k+1])
    );
  end

  // output register; an invalid request reports all zeros
  ubfs_pkg::item_t fin;
  assign fin = mitm[NMOD];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= mv[NMOD];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.ok) begin
        m_tdata <= {1'b0, fin.port, fin.two, fin.eight, fin.pev, fin.pen,
                    mmask[NMOD], 16'(mdiv[NMOD]), fin.fast, 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // a rejected request carries nothing but zeros
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[31:1] == '0)
    else $error("rejected result carries settings");

  // an accepted request always yields a usable divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[17:2] != '0)
    else $error("zero divisor on a valid result");

  // fast clock only serves rates above the slow limit, so divisor stays small
  a_fast_div: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && m_tdata[1] |-> m_tdata[17:2] <= 16'd104)
    else $error("fast clock divisor out of range");

  // a held result leaves the pipeline frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(d_item) && $stable(d_valid))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

>>> verif/tb.sv
// self-checking testbench for the uart baud and frame set-up block
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic        ok;
    logic        clock_source;
    logic [15:0] divisor;
    logic [7:0]  modulation;
    logic        parity_enable;
    logic        parity_even;
    logic        eight_bit_chars;
    logic        two_stop_bits;
    logic        target_port;
  } setup_t;

  // computes expected settings and holds them in arrival order
  class setup_scoreboard;
    setup_t pending_q[$];
    int     mismatches;

    function setup_t compute(logic [16:0] baud, logic [7:0] pch, logic [7:0] dbits,
                             logic [7:0] sbits, logic port);
      setup_t r;
      bit     valid;
      longint clk_hz, base, ideal, e0, e1;
      int     sum;
      r = '0;
      valid = (baud >= ubfs_pkg::MIN_BAUD) && (baud <= ubfs_pkg::MAX_BAUD);
      if (pch == ubfs_pkg::CH_N_LO || pch == ubfs_pkg::CH_N_UP) begin
        r.parity_enable = 1'b0;
      end else if (pch == ubfs_pkg::CH_P_LO || pch == ubfs_pkg::CH_P_UP) begin
        r.parity_enable = 1'b1;
        r.parity_even = 1'b1;
      end else if (pch == ubfs_pkg::CH_O_LO || pch == ubfs_pkg::CH_O_UP) begin
        r.parity_enable = 1'b1;
      end else begin
        valid = 0;
      end
      if (dbits != 8'd7 && dbits != 8'd8) valid = 0;
      if (sbits != 8'd1 && sbits != 8'd2) valid = 0;
      if (!valid) return '0;
      r.ok = 1'b1;
      r.clock_source = (baud > ubfs_pkg::SLOW_MAX);
      clk_hz = r.clock_source ? longint'(ubfs_pkg::FAST_HZ) : longint'(ubfs_pkg::SLOW_HZ);
      r.divisor = 16'(clk_hz / longint'(baud));
      sum = 0;
      for (int i = 0; i < 8; i++) begin
        base = longint'(i + 1) * longint'(r.divisor) + longint'(sum);
        ideal = 100 * longint'(i + 1);
        e0 = (100 * longint'(baud) * base) / clk_hz - ideal;
        e1 = (100 * longint'(baud) * (base + 1)) / clk_hz - ideal;
        if ((e1 < 0 ? -e1 : e1) < (e0 < 0 ? -e0 : e0)) begin
          r.modulation[i] = 1'b1;
          sum++;
        end
      end
      r.eight_bit_chars = (dbits == 8'd8);
      r.two_stop_bits = (sbits == 8'd2);
      r.target_port = port;
      return r;
    endfunction

    function void note_request(logic [47:0] word);
      pending_q.push_back(compute(word[16:0], word[24:17], word[32:25], word[40:33],
                                  word[41]));
    endfunction

    function void check_result(logic [31:0] word);
      setup_t got, want;
      got = {word[0], word[1], word[17:2], word[25:18], word[26], word[27], word[28],
             word[29], word[30]};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", word);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want || word[31] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected ok=%0d src=%0d div=%0d mod=%h pe=%0d ev=%0d",
                   want.ok, want.clock_source, want.divisor, want.modulation,
                   want.parity_enable, want.parity_even);
          $display("  expected e8=%0d s2=%0d pt=%0d", want.eight_bit_chars,
                   want.two_stop_bits, want.target_port);
          $display("  got ok=%0d src=%0d div=%0d mod=%h pe=%0d ev=%0d",
                   got.ok, got.clock_source, got.divisor, got.modulation,
                   got.parity_enable, got.parity_even);
          $display("  got e8=%0d s2=%0d pt=%0d top=%0d", got.eight_bit_chars,
                   got.two_stop_bits, got.target_port, word[31]);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;

  setup_scoreboard board = new();
  int send_idle_pct = 12;
  int recv_idle_pct = 72;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  uart_baud_and_frame_setup u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // receiver side: random backpressure, checks every accepted transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog over cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("uart_baud_and_frame_setup verification failed");
      $finish;
    end
  end

  // drive one request and hold it until accepted
  task automatic send_request(logic [16:0] baud, logic [7:0] pch, logic [7:0] dbits,
                              logic [7:0] sbits, logic port);
    logic [47:0] word;
    word = {6'b0, port, sbits, dbits, pch, baud};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(word);
  endtask

  function automatic logic [7:0] pick_parity();
    logic [7:0] letters[6] = '{ubfs_pkg::CH_N_LO, ubfs_pkg::CH_N_UP, ubfs_pkg::CH_P_LO,
                               ubfs_pkg::CH_P_UP, ubfs_pkg::CH_O_LO, ubfs_pkg::CH_O_UP};
    return letters[$urandom_range(5)];
  endfunction

  task automatic random_request();
    logic [16:0] baud;
    logic [7:0]  pch, dbits, sbits;
    int          pick;
    pick = $urandom_range(99);
    baud = (pick < 40) ? 17'($urandom_range(9600, 300))
         : (pick < 80) ? 17'($urandom_range(115200, 9601)) : 17'($urandom);
    pch = ($urandom_range(9) == 0) ? 8'($urandom) : pick_parity();
    dbits = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8, 7));
    sbits = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2, 1));
    send_request(baud, pch, dbits, sbits, 1'($urandom));
  endtask

  initial begin
    int drain;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: baud range edges, clock switchover, all letters, bad arguments
    send_request(17'd300, ubfs_pkg::CH_N_LO, 8'd8, 8'd1, 1'b0);
    send_request(17'd299, ubfs_pkg::CH_N_LO, 8'd8, 8'd1, 1'b1);
    send_request(17'd0, ubfs_pkg::CH_P_UP, 8'd7, 8'd2, 1'b1);
    send_request(17'd9600, ubfs_pkg::CH_P_LO, 8'd7, 8'd2, 1'b1);
    send_request(17'd9601, ubfs_pkg::CH_O_LO, 8'd8, 8'd1, 1'b0);
    send_request(17'd115200, ubfs_pkg::CH_O_UP, 8'd8, 8'd2, 1'b1);
    send_request(17'd115201, ubfs_pkg::CH_N_UP, 8'd8, 8'd1, 1'b1);
    send_request(17'h1ffff, ubfs_pkg::CH_N_LO, 8'd8, 8'd1, 1'b1);
    send_request(17'd2400, 8'h41, 8'd8, 8'd1, 1'b1);
    send_request(17'd2400, 8'hff, 8'd8, 8'd1, 1'b1);
    send_request(17'd19200, ubfs_pkg::CH_N_LO, 8'd6, 8'd1, 1'b1);
    send_request(17'd19200, ubfs_pkg::CH_N_LO, 8'hff, 8'd1, 1'b0);
    send_request(17'd19200, ubfs_pkg::CH_N_LO, 8'd8, 8'd0, 1'b1);
    send_request(17'd19200, ubfs_pkg::CH_N_LO, 8'd8, 8'd3, 1'b1);
    send_request(17'd19200, ubfs_pkg::CH_N_LO, 8'd8, 8'hff, 1'b1);
    send_request(17'd57600, ubfs_pkg::CH_P_UP, 8'd7, 8'd1, 1'b1);
    send_request(17'd38400, ubfs_pkg::CH_O_LO, 8'd8, 8'd2, 1'b0);
    send_request(17'd4800, ubfs_pkg::CH_N_UP, 8'd7, 8'd1, 1'b1);
    send_request(17'd1200, ubfs_pkg::CH_P_LO, 8'd8, 8'd2, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 72;
        recv_idle_pct = 12;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (180) random_request();
    end
    s_tvalid <= 0;

    // wait for outstanding results, then let the pipeline settle
    while (board.pending_q.size() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("uart_baud_and_frame_setup verification clean");
    end else begin
      $display("uart_baud_and_frame_setup verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
